// ----- sv/sha256_stream_hash_defines.svh -----
// Assertion macros for the stream hasher.
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/sha_pkg.sv -----
package sha_pkg;

  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic       has_byte;
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
      32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
      32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
      32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
      32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
      32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
      32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
      32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
      32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
      32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
      32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- sv/sha_front.sv -----
module sha_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [1:0]     op,
  input  logic [7:0]     data_byte,
  output logic           full,
  output logic           cmd_valid,
  output sha_pkg::cmd_t  cmd,
  input  logic           cmd_take
);

  sha_pkg::cmd_t q_r [sha_pkg::QDEPTH];
  logic [sha_pkg::QAW-1:0] wp_r, rp_r;
  logic [sha_pkg::QAW:0] cnt_r;
  logic acc, deq;
  sha_pkg::cmd_t c_new;

  assign full = (cnt_r == 3'(sha_pkg::QDEPTH));
  assign acc = push && !full && (op != sha_pkg::OP_NONE);
  assign deq = cmd_valid && cmd_take;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  always_comb begin
    c_new.has_byte = (op != sha_pkg::OP_FINISH);
    c_new.fin = (op != sha_pkg::OP_ABSORB);
    c_new.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) begin
        wp_r <= wp_r + 1'b1;
      end
      if (deq) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (acc ? 1'b1 : 1'b0) - (deq ? 1'b1 : 1'b0);
    end
    if (acc) begin
      q_r[wp_r] <= c_new;
    end
  end

endmodule

// ----- sv/sha_back.sv -----
module sha_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  sha_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t state_r;
  logic [511:0] blk_r;
  logic [5:0]  fill_r, pos_r, t_r;
  logic [63:0] bits_r;
  logic [255:0] h_r;
  logic [31:0] v_r [8];
  logic        fin_r, final_r, over_r, marked_r;
  logic [2:0]  oidx_r;

  logic [31:0] s1, ch, x1, s0, mj, wt, wnew, w1, w9, w14;

  assign cmd_take = (state_r == S_IDLE);
  assign empty = (state_r != S_OUT);
  assign digest_word = h_r[255 - 32*oidx_r -: 32];
  assign word_index = oidx_r;
  assign last_word = (oidx_r == 3'd7);

  always_comb begin
    wt = blk_r[511:480];
    w1 = blk_r[479:448];
    w9 = blk_r[223:192];
    w14 = blk_r[63:32];
    wnew = (sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10))
         + w9
         + (sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3))
         + wt;
    s1 = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    x1 = v_r[7] + s1 + ch + sha_pkg::round_k(t_r) + wt;
    s0 = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      h_r <= sha_pkg::H_INIT;
      fin_r <= 1'b0;
      final_r <= 1'b0;
      over_r <= 1'b0;
      marked_r <= 1'b0;
      oidx_r <= '0;
      pos_r <= '0;
      t_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            fin_r <= cmd.fin;
            final_r <= 1'b0;
            marked_r <= 1'b0;
            if (cmd.has_byte) begin
              blk_r <= {blk_r[503:0], cmd.data};
              fill_r <= fill_r + 1'b1;
              bits_r <= bits_r + 64'd8;
              if (fill_r == 6'd63) begin
                state_r <= S_LOAD;
              end else if (cmd.fin) begin
                pos_r <= fill_r + 1'b1;
                state_r <= S_MARK;
              end
            end else begin
              pos_r <= fill_r;
              state_r <= S_MARK;
            end
          end
        end
        S_MARK: begin
          blk_r <= {blk_r[503:0], 8'h80};
          pos_r <= pos_r + 1'b1;
          over_r <= (pos_r >= 6'd56);
          marked_r <= 1'b1;
          if (pos_r == 6'd63) begin
            state_r <= S_LOAD;
          end else begin
            state_r <= S_PAD;
          end
        end
        S_PAD: begin
          if (!over_r && pos_r == 6'd56) begin
            blk_r <= {blk_r[447:0], bits_r};
            final_r <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            blk_r <= {blk_r[503:0], 8'h00};
            pos_r <= pos_r + 1'b1;
            if (pos_r == 6'd63) begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) begin
            v_r[i] <= h_r[255 - 32*i -: 32];
          end
          t_r <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          blk_r <= {blk_r[479:0], wnew};
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + x1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= x1 + s0 + mj;
          t_r <= t_r + 1'b1;
          if (t_r == 6'd63) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[255 - 32*i -: 32] <= h_r[255 - 32*i -: 32] + v_r[i];
          end
          if (final_r) begin
            oidx_r <= '0;
            state_r <= S_OUT;
          end else if (fin_r) begin
            pos_r <= 6'd0;
            over_r <= 1'b0;
            if (marked_r) begin
              state_r <= S_PAD;
            end else begin
              state_r <= S_MARK;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (pop) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              h_r <= sha_pkg::H_INIT;
              fill_r <= '0;
              bits_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/sha256_stream_hash.sv -----
// SHA-256 stream hasher.
// Input queue: drive in_op/in_data_byte with push while full is low; one
// beat per message byte, op 1 or 2 closes the message. Op 3 is dropped.
// Result queue: eight beats per message, digest words H0..H7, while empty
// is low; pop takes a beat. last_word marks the eighth.
// A four-entry command queue sits between the front and the back end, so
// bytes are taken while a block compresses.
// The back end takes one byte per cycle while idle; command intake stalls
// during each block compression (load, 64 rounds, add).
// Finish writes the 0x80 byte, then the zero padding one byte a cycle,
// then the length, and runs one or two block compressions before the
// first digest beat.
// Reset returns the hash words to the initial values and clears counts.
// A stalled receiver holds the digest on the result ports; the command
// queue fills and full rises until the digest is popped.
`include "sha256_stream_hash_defines.svh"
module sha256_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic cmd_valid, cmd_take;
  sha_pkg::cmd_t cmd;

  sha_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .op(in_op), .data_byte(in_data_byte),
    .full(full), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  sha_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .empty(empty), .pop(pop), .digest_word(out_digest_word),
    .word_index(out_word_index), .last_word(out_last_word)
  );

  `SHA_ASSERT_NEXT(a_idx_adv, clk, rst_n, !empty && pop && !out_last_word,
                   out_word_index == $past(out_word_index) + 3'd1)
  `SHA_ASSERT_IMPL(a_last_idx, clk, rst_n, !empty && out_last_word, out_word_index == 3'd7)
  `SHA_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_digest_word))

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  in_op;
  logic [7:0]  in_data_byte;
  logic        empty;
  logic        pop;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hash u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_data_byte(in_data_byte),
    .empty(empty), .pop(pop), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word)
  );

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  data;
    logic        typed;
    logic [31:0] h0;
  } stim_row_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
    32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
    32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
    32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
    32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
    32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
    32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
    32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
    32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic [31:0]  sum_h [8];
  logic [7:0]   msg_blk [64];
  logic [5:0]   fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];
  logic [31:0]  typed_h0_q [$];
  int           errors;
  int           idle_pct;
  bit           pop_quiet;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] x1, x2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_blk[4*t], msg_blk[4*t+1], msg_blk[4*t+2], msg_blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = sum_h;
    for (int t = 0; t < 64; t++) begin
      x1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
      x2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + x1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = x1 + x2;
    end
    for (int i = 0; i < 8; i++) sum_h[i] += v[i];
  endtask

  task automatic hash_reset();
    sum_h = IV;
    fill = '0;
    msg_bits = '0;
  endtask

  task automatic hash_item(logic [1:0] op, logic [7:0] data);
    int pos;
    if (op == sha_pkg::OP_NONE) return;
    if (op != sha_pkg::OP_FINISH) begin
      msg_blk[fill] = data;
      fill++;
      msg_bits += 64'd8;
      if (fill == 0) compress();
    end
    if (op == sha_pkg::OP_ABSORB) return;
    pos = fill;
    msg_blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) msg_blk[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < 56) msg_blk[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_blk[56+i] = msg_bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{sum_h[i], 3'(i), i == 7});
    hash_reset();
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send(logic [1:0] op, logic [7:0] data);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_data_byte <= data;
    do @(posedge clk); while (full);
    hash_item(op, data);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (digest_q.size() != 0);
  endtask

  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= pop_quiet || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected");
        errors++;
      end else begin
        digest_beat_t e;
        e = digest_q.pop_front();
        if (e.idx == 0 && typed_h0_q.size() != 0) begin
          logic [31:0] h0;
          h0 = typed_h0_q.pop_front();
          if (h0 != e.word) begin
            $error("digest_word h0 table %h predictor %h", h0, e.word);
            errors++;
          end
        end
        if (out_digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.idx) begin
          $error("word_index expected %0d actual %0d", e.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== e.last) begin
          $error("last_word expected %0d actual %0d", e.last, out_last_word);
          errors++;
        end
      end
    end
  end

  stim_row_t rows [$];

  initial begin
    int n, len, waited;
    errors = 0;
    idle_pct = 29;
    pop_quiet = 0;
    rst_n = 0;
    push = 0;
    in_op = sha_pkg::OP_ABSORB;
    in_data_byte = '0;
    hash_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // empty message, "abc", ignored op, then 0x00/0xff extremes
    rows.push_back('{sha_pkg::OP_FINISH, 8'h00, 1, 32'he3b0c442});
    rows.push_back('{sha_pkg::OP_NONE, 8'hff, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB, 8'h61, 0, 0});
    rows.push_back('{sha_pkg::OP_NONE, 8'h5a, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB, 8'h62, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB_FINISH, 8'h63, 1, 32'hba7816bf});
    rows.push_back('{sha_pkg::OP_ABSORB_FINISH, 8'h00, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB, 8'hff, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB, 8'haa, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB, 8'h55, 0, 0});
    rows.push_back('{sha_pkg::OP_FINISH, 8'hff, 0, 0});
    rows.push_back('{sha_pkg::OP_ABSORB_FINISH, 8'hff, 0, 0});
    foreach (rows[i]) begin
      if (rows[i].typed) typed_h0_q.push_back(rows[i].h0);
      send(rows[i].op, rows[i].data);
    end
    drain();

    // block-boundary lengths: 56 and 64 bytes
    for (int k = 0; k < 2; k++) begin
      len = k == 0 ? 55 : 63;
      for (int i = 0; i < len; i++) send(sha_pkg::OP_ABSORB, 8'($urandom));
      send(sha_pkg::OP_ABSORB_FINISH, 8'($urandom));
    end
    drain();

    // long stretch without idling, receiver always ready
    idle_pct = 0;
    pop_quiet = 1;
    for (int m = 0; m < 4; m++) begin
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) send(sha_pkg::OP_ABSORB, 8'($urandom));
      send($urandom_range(1) ? sha_pkg::OP_FINISH : sha_pkg::OP_ABSORB_FINISH,
           8'($urandom));
    end
    idle_pct = 29;
    pop_quiet = 0;

    n = 0;
    while (n < 80) begin
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        logic [1:0] op;
        op = ($urandom_range(19) == 0) ? sha_pkg::OP_NONE : sha_pkg::OP_ABSORB;
        send(op, 8'($urandom));
        if (op != sha_pkg::OP_NONE) n++;
      end
      send($urandom_range(1) ? sha_pkg::OP_FINISH : sha_pkg::OP_ABSORB_FINISH,
           8'($urandom));
      n++;
      if ($urandom_range(7) == 0) drain();
    end

    push <= 1'b0;
    waited = 0;
    while (digest_q.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (300) @(negedge clk);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
